// File: rtl/core/arb_pkg.sv
`timescale 1ns / 1ps
// arb_pkg: shared constants, beat types and saturation helpers for the
// affine rectangle bounding box pipeline. no dependencies.

package arb_pkg;

	localparam int CW   = 32;          // coordinate width
	localparam int FB   = 16;          // fraction bits
	localparam int PW   = 2 * CW + 1;  // coef x corner product
	localparam int SW   = PW - FB;     // product after fraction drop
	localparam int SUMW = SW + 2;      // two products plus translation

	localparam int NREG   = 6;
	localparam int IDX_W  = $clog2(NREG);

	localparam logic [IDX_W-1:0] REG_COEF_A  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_COEF_B  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_COEF_C  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_COEF_D  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SHIFT_X = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_SHIFT_Y = IDX_W'(5);

	typedef struct packed {
		logic signed [CW-1:0] rect_x;
		logic signed [CW-1:0] rect_y;
		logic signed [CW-1:0] rect_w;
		logic signed [CW-1:0] rect_h;
	} rect_t;

	typedef struct packed {
		logic signed [CW-1:0] box_x;
		logic signed [CW-1:0] box_y;
		logic        [CW-2:0] box_w;
		logic        [CW-2:0] box_h;
	} box_t;

	// stage load enables, one per stage inside the axis datapath
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stg_en_t;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
		logic [SUMW-CW:0] top;
		top = v[SUMW-1:CW-1];
		if ((&top) || !(|top)) begin
			return v[CW-1:0];
		end else if (v[SUMW-1]) begin
			return {1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	function automatic logic [CW-2:0] sat_extent(input logic [SUMW:0] e);
		if (|e[SUMW:CW-1]) begin
			return {(CW-1){1'b1}};
		end else begin
			return e[CW-2:0];
		end
	endfunction

endpackage

// File: rtl/core/affine_rect_bounding_box.sv
`timescale 1ns / 1ps
// affine_rect_bounding_box: top level, transform registers, corner stage,
// valid chain and handshakes. uses arb_pkg and arb_axis.

// Takes one rectangle beat per clock and returns the axis-aligned bounding
// box of its four corners after the affine transform held in the six
// coefficient registers. From input accept to output valid a beat passes
// five register stages: corner sums, the eight 32x33
// multipliers, corner min and max, translation sum, saturation and extent.
// Throughput is one beat per cycle; a stalled output holds the pipeline
// and bubbles are squeezed out. Write the registers only while idle.

module affine_rect_bounding_box (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [arb_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [arb_pkg::CW-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  arb_pkg::rect_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output arb_pkg::box_t                 out_data
);
	import arb_pkg::*;

	logic signed [CW-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic signed [CW-1:0] shift_x_q, shift_y_q;

	logic signed [CW:0] px0_s1, px1_s1, py0_s1, py1_s1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	stg_en_t en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= CW'(1) <<< FB;
			coef_b_q  <= '0;
			coef_c_q  <= '0;
			coef_d_q  <= CW'(1) <<< FB;
			shift_x_q <= '0;
			shift_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COEF_A:  coef_a_q  <= cfg_data;
				REG_COEF_B:  coef_b_q  <= cfg_data;
				REG_COEF_C:  coef_c_q  <= cfg_data;
				REG_COEF_D:  coef_d_q  <= cfg_data;
				REG_SHIFT_X: shift_x_q <= cfg_data;
				REG_SHIFT_Y: shift_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the next one moves on
	assign adv5 = !v_s5 || out_ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	assign en.s2 = adv2;
	assign en.s3 = adv3;
	assign en.s4 = adv4;
	assign en.s5 = adv5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			px0_s1 <= {in_data.rect_x[CW-1], in_data.rect_x};
			py0_s1 <= {in_data.rect_y[CW-1], in_data.rect_y};
			px1_s1 <= {in_data.rect_x[CW-1], in_data.rect_x}
				+ {in_data.rect_w[CW-1], in_data.rect_w};
			py1_s1 <= {in_data.rect_y[CW-1], in_data.rect_y}
				+ {in_data.rect_h[CW-1], in_data.rect_h};
		end
	end

	arb_axis u_axis_x (
		.clk     (clk),
		.en      (en),
		.k_p     (coef_a_q),
		.k_q     (coef_c_q),
		.t       (shift_x_q),
		.p0      (px0_s1),
		.p1      (px1_s1),
		.q0      (py0_s1),
		.q1      (py1_s1),
		.box_min (out_data.box_x),
		.box_ext (out_data.box_w)
	);

	arb_axis u_axis_y (
		.clk     (clk),
		.en      (en),
		.k_p     (coef_b_q),
		.k_q     (coef_d_q),
		.t       (shift_y_q),
		.p0      (px0_s1),
		.p1      (px1_s1),
		.q0      (py0_s1),
		.q1      (py1_s1),
		.box_min (out_data.box_y),
		.box_ext (out_data.box_h)
	);

	assign out_valid = v_s5;

endmodule

// File: rtl/core/arb_axis.sv
`timescale 1ns / 1ps
// arb_axis: one output axis of the bounding box, stages two to five:
// products, corner min and max, translation sum, saturation. uses arb_pkg.

module arb_axis (
	input  logic                         clk,
	input  arb_pkg::stg_en_t             en,
	input  logic signed [arb_pkg::CW-1:0] k_p,
	input  logic signed [arb_pkg::CW-1:0] k_q,
	input  logic signed [arb_pkg::CW-1:0] t,
	input  logic signed [arb_pkg::CW:0]   p0,
	input  logic signed [arb_pkg::CW:0]   p1,
	input  logic signed [arb_pkg::CW:0]   q0,
	input  logic signed [arb_pkg::CW:0]   q1,
	output logic signed [arb_pkg::CW-1:0] box_min,
	output logic        [arb_pkg::CW-2:0] box_ext
);
	import arb_pkg::*;

	logic signed [PW-1:0]   prod_p0, prod_p1, prod_q0, prod_q1;
	logic signed [SW-1:0]   tp0_s2, tp1_s2, tq0_s2, tq1_s2;
	logic signed [SW-1:0]   pmin_s3, pmax_s3, qmin_s3, qmax_s3;
	logic signed [SUMW-1:0] min_s4, max_s4;
	logic        [SUMW:0]   ext;
	logic signed [CW-1:0]   box_min_s5;
	logic        [CW-2:0]   box_ext_s5;

	// corner coordinates enter the products separately, so the box is
	// the sum of per-term extremes
	always_comb begin
		prod_p0 = k_p * p0;
		prod_p1 = k_p * p1;
		prod_q0 = k_q * q0;
		prod_q1 = k_q * q1;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			tp0_s2 <= prod_p0[PW-1:FB];
			tp1_s2 <= prod_p1[PW-1:FB];
			tq0_s2 <= prod_q0[PW-1:FB];
			tq1_s2 <= prod_q1[PW-1:FB];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pmin_s3 <= (tp1_s2 < tp0_s2) ? tp1_s2 : tp0_s2;
			pmax_s3 <= (tp1_s2 < tp0_s2) ? tp0_s2 : tp1_s2;
			qmin_s3 <= (tq1_s2 < tq0_s2) ? tq1_s2 : tq0_s2;
			qmax_s3 <= (tq1_s2 < tq0_s2) ? tq0_s2 : tq1_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			min_s4 <= {{2{pmin_s3[SW-1]}}, pmin_s3} + {{2{qmin_s3[SW-1]}}, qmin_s3}
				+ {{(SUMW-CW){t[CW-1]}}, t};
			max_s4 <= {{2{pmax_s3[SW-1]}}, pmax_s3} + {{2{qmax_s3[SW-1]}}, qmax_s3}
				+ {{(SUMW-CW){t[CW-1]}}, t};
		end
	end

	assign ext = {max_s4[SUMW-1], max_s4} - {min_s4[SUMW-1], min_s4};

	always_ff @(posedge clk) begin
		if (en.s5) begin
			box_min_s5 <= sat_coord(min_s4);
			box_ext_s5 <= sat_extent(ext);
		end
	end

	assign box_min = box_min_s5;
	assign box_ext = box_ext_s5;

endmodule

// File: rtl/core/arb_checker.sv
`timescale 1ns / 1ps
// arb_checker: port-level checks on the bounding box pipeline, bound to the
// top level. uses arb_pkg.

module arb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input arb_pkg::box_t             out_data
);
	import arb_pkg::*;

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// a draining output lets the whole pipeline move
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// an empty output stage never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// nothing comes out of a pipeline that has taken no input beat while its stages drained
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) ##1 !(in_valid && in_ready) ##1 !(in_valid && in_ready)
		##1 !(in_valid && in_ready) ##1 !(in_valid && in_ready) ##1 !out_valid
		|=> !out_valid)
		else $error("output beat without an input beat");

endmodule

bind affine_rect_bounding_box arb_checker u_arb_checker (.*);
